### rtl/core/wsjd_pkg.sv
package wsjd_pkg;

    // Fixed widths of the item fields
    localparam int JOB_W    = 16;
    localparam int WORKER_W = 2;
    localparam int SOURCE_W = 2;

    // Defaults for the top-level parameters
    localparam int NUM_WORKERS_DEF = 4;
    localparam int FIFO_DEPTH_DEF  = 1024;
    localparam int JOB_BITS_DEF    = 16;

    // Source codes reported with a dequeued job
    localparam logic [SOURCE_W-1:0] SRC_OWN    = 2'd0;
    localparam logic [SOURCE_W-1:0] SRC_GLOBAL = 2'd1;
    localparam logic [SOURCE_W-1:0] SRC_STOLEN = 2'd2;

    // Status of the steal scan unit
    typedef struct packed {
        logic done;
        logic found;
    } scan_status_t;

endpackage

### rtl/core/wsjd_ram.sv
module wsjd_ram #(
    parameter int WIDTH = wsjd_pkg::JOB_W,
    parameter int DEPTH = wsjd_pkg::FIFO_DEPTH_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write one entry, register one read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/wsjd_scan.sv
module wsjd_scan #(
    parameter int NUM_WORKERS = wsjd_pkg::NUM_WORKERS_DEF,
    localparam int WIDX       = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [WIDX-1:0]          start_worker,
    input  logic [NUM_WORKERS-1:0]   nonempty,
    output wsjd_pkg::scan_status_t   status,
    output logic [WIDX-1:0]          victim
);

    localparam logic [WIDX-1:0] LAST = WIDX'(NUM_WORKERS - 1);

    logic            busy_reg;
    logic            done_reg;
    logic            found_reg;
    logic [WIDX-1:0] cur_reg;
    logic [WIDX-1:0] left_reg;

    // Step to the next worker with wrap
    function automatic logic [WIDX-1:0] next_worker(input logic [WIDX-1:0] idx);
        next_worker = (idx == LAST) ? '0 : idx + 1'b1;
    endfunction

    // Visit one other worker per cycle, stop at the first non-empty FIFO
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            found_reg <= 1'b0;
            cur_reg   <= '0;
            left_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                found_reg <= 1'b0;
                cur_reg   <= next_worker(start_worker);
                left_reg  <= LAST;
            end
            else if (busy_reg)
            begin
                priority if (left_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else if (nonempty[cur_reg])
                begin
                    busy_reg  <= 1'b0;
                    done_reg  <= 1'b1;
                    found_reg <= 1'b1;
                end
                else
                begin
                    cur_reg  <= next_worker(cur_reg);
                    left_reg <= left_reg - 1'b1;
                end
            end
        end
    end

    assign status.done  = done_reg;
    assign status.found = found_reg;
    assign victim       = cur_reg;

endmodule

### rtl/core/work_stealing_job_dispatcher.sv
// Work-stealing job dispatcher: one FIFO of job handles per worker plus one
// global FIFO, all kept in a single job RAM, with head, tail and count of
// each FIFO in a small pointer RAM. An enqueue (command 0) stores the job in
// the worker's FIFO when has_context is set, else in the global FIFO, and
// flags dropped when that FIFO is full. A dequeue (command 1) returns the
// head of the worker's own FIFO, else of the global FIFO, else steals from
// the first non-empty other worker upward from worker+1 with wrap; job_valid
// is low when every FIFO is empty. Every item gives exactly one result beat.
// The block takes one item at a time and in_ready is high only while idle:
// an enqueue reads the pointer record, then writes the job and the record;
// a dequeue picks its FIFO, runs the steal scan when needed, reads the
// pointer record, then reads the job RAM. The result beat is then held
// until out_ready. The reads of the pointer RAM and of the job RAM are
// registered, and the steal scan tests one worker per cycle. No clearing
// pass is needed after reset.
module work_stealing_job_dispatcher #(
    parameter int NUM_WORKERS = wsjd_pkg::NUM_WORKERS_DEF,
    parameter int FIFO_DEPTH  = wsjd_pkg::FIFO_DEPTH_DEF,
    parameter int JOB_BITS    = wsjd_pkg::JOB_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          command,
    input  logic                          has_context,
    input  logic [wsjd_pkg::WORKER_W-1:0] worker,
    input  logic [wsjd_pkg::JOB_W-1:0]    job,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          job_valid,
    output logic [wsjd_pkg::JOB_W-1:0]    job_out,
    output logic [wsjd_pkg::SOURCE_W-1:0] source,
    output logic [wsjd_pkg::WORKER_W-1:0] victim,
    output logic                          dropped
);

    localparam int JW    = wsjd_pkg::JOB_W;
    localparam int WW    = wsjd_pkg::WORKER_W;
    localparam int WIDX  = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1;
    localparam int NQ    = NUM_WORKERS + 1;
    localparam int QB    = $clog2(NQ);
    localparam int PB    = $clog2(FIFO_DEPTH);
    localparam int CB    = $clog2(FIFO_DEPTH + 1);
    localparam int REC_W = 2 * PB + CB;
    localparam int JDEP  = NQ * FIFO_DEPTH;
    localparam int AB    = $clog2(JDEP);

    localparam logic [QB-1:0] GLOBAL_Q = QB'(NUM_WORKERS);
    localparam logic [PB-1:0] PTR_LAST = PB'(FIFO_DEPTH - 1);
    localparam logic [CB-1:0] CNT_FULL = CB'(FIFO_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PICK,
        S_SCAN,
        S_PTR_RD,
        S_PTR_USE,
        S_JOB_RD,
        S_OUT
    } state_t;

    state_t                    state_reg;
    logic                      cmd_reg;
    logic [QB-1:0]             q_reg;
    logic [WIDX-1:0]           w_reg;
    logic [JOB_BITS-1:0]       job_reg;
    logic [NQ-1:0]             nonempty_reg;
    logic [NQ-1:0]             ptr_valid_reg;
    logic                      job_valid_reg;
    logic [JW-1:0]             job_out_reg;
    logic [WW-1:0]             source_reg;
    logic [WW-1:0]             victim_reg;
    logic                      dropped_reg;

    logic [WW-1:0]             w_mod;
    logic [WIDX-1:0]           w_idx;
    logic [JOB_BITS-1:0]       job_in;
    logic [JW-1:0]             job_rd16;
    logic                      scan_start;
    wsjd_pkg::scan_status_t    scan_status;
    logic [WIDX-1:0]           scan_victim;

    logic                      ptr_wr_en;
    logic [REC_W-1:0]          ptr_wr_data;
    logic                      ptr_rd_en;
    logic [REC_W-1:0]          ptr_rd_data;
    logic [REC_W-1:0]          ptr_rec;
    logic [PB-1:0]             rec_head;
    logic [PB-1:0]             rec_tail;
    logic [CB-1:0]             rec_count;
    logic [PB-1:0]             head_inc;
    logic [PB-1:0]             tail_inc;
    logic                      is_full;
    logic [AB-1:0]             q_base;

    logic                      job_wr_en;
    logic [AB-1:0]             job_wr_addr;
    logic                      job_rd_en;
    logic [AB-1:0]             job_rd_addr;
    logic [JOB_BITS-1:0]       job_rd_data;

    // Fold the worker field into range
    always_comb
    begin
        w_mod = worker;
        for (int i = 0; i < 3; i++)
        begin
            if (32'(w_mod) >= NUM_WORKERS)
            begin
                w_mod = w_mod - WW'(NUM_WORKERS);
            end
        end
        w_idx = WIDX'(w_mod);
    end

    // Mask the job handle to the stored width and back to the port width
    generate
        if (JOB_BITS > JW)
        begin : g_wide
            assign job_in   = {{(JOB_BITS - JW){1'b0}}, job};
            assign job_rd16 = job_rd_data[JW-1:0];
        end
        else if (JOB_BITS == JW)
        begin : g_equal
            assign job_in   = job;
            assign job_rd16 = job_rd_data;
        end
        else
        begin : g_narrow
            assign job_in   = job[JOB_BITS-1:0];
            assign job_rd16 = {{(JW - JOB_BITS){1'b0}}, job_rd_data};
        end
    endgenerate

    // Unpack the pointer record; a never-written record reads as zero
    assign ptr_rec   = ptr_valid_reg[q_reg] ? ptr_rd_data : '0;
    assign rec_head  = ptr_rec[REC_W-1 -: PB];
    assign rec_tail  = ptr_rec[CB +: PB];
    assign rec_count = ptr_rec[CB-1:0];
    assign head_inc  = (rec_head == PTR_LAST) ? '0 : rec_head + 1'b1;
    assign tail_inc  = (rec_tail == PTR_LAST) ? '0 : rec_tail + 1'b1;
    assign is_full   = (rec_count == CNT_FULL);
    assign q_base    = AB'(q_reg) * AB'(FIFO_DEPTH);

    // Drive the RAM ports from the current step
    always_comb
    begin
        ptr_rd_en   = (state_reg == S_PTR_RD);
        ptr_wr_en   = 1'b0;
        ptr_wr_data = ptr_rec;
        job_wr_en   = 1'b0;
        job_wr_addr = q_base + AB'(rec_tail);
        job_rd_en   = 1'b0;
        job_rd_addr = q_base + AB'(rec_head);
        if (state_reg == S_PTR_USE)
        begin
            if (cmd_reg)
            begin
                job_rd_en   = 1'b1;
                ptr_wr_en   = 1'b1;
                ptr_wr_data = {head_inc, rec_tail, rec_count - 1'b1};
            end
            else if (!is_full)
            begin
                job_wr_en   = 1'b1;
                ptr_wr_en   = 1'b1;
                ptr_wr_data = {rec_head, tail_inc, rec_count + 1'b1};
            end
        end
    end

    // Start the steal scan when own and global FIFOs are empty
    assign scan_start = (state_reg == S_PICK) && !nonempty_reg[w_reg]
                        && !nonempty_reg[GLOBAL_Q];

    // Sequence one item and hold its result beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cmd_reg       <= 1'b0;
            q_reg         <= '0;
            w_reg         <= '0;
            job_reg       <= '0;
            nonempty_reg  <= '0;
            ptr_valid_reg <= '0;
            job_valid_reg <= 1'b0;
            job_out_reg   <= '0;
            source_reg    <= '0;
            victim_reg    <= '0;
            dropped_reg   <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        cmd_reg       <= command;
                        w_reg         <= w_idx;
                        job_reg       <= job_in;
                        q_reg         <= (has_context || command) ? QB'(w_idx) : GLOBAL_Q;
                        job_valid_reg <= 1'b0;
                        job_out_reg   <= '0;
                        source_reg    <= '0;
                        victim_reg    <= '0;
                        dropped_reg   <= 1'b0;
                        state_reg     <= command ? S_PICK : S_PTR_RD;
                    end
                end
                S_PICK:
                begin
                    priority if (nonempty_reg[w_reg])
                    begin
                        source_reg <= wsjd_pkg::SRC_OWN;
                        state_reg  <= S_PTR_RD;
                    end
                    else if (nonempty_reg[GLOBAL_Q])
                    begin
                        q_reg      <= GLOBAL_Q;
                        source_reg <= wsjd_pkg::SRC_GLOBAL;
                        state_reg  <= S_PTR_RD;
                    end
                    else
                    begin
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (scan_status.done)
                    begin
                        if (scan_status.found)
                        begin
                            q_reg      <= QB'(scan_victim);
                            source_reg <= wsjd_pkg::SRC_STOLEN;
                            victim_reg <= WW'(scan_victim);
                            state_reg  <= S_PTR_RD;
                        end
                        else
                        begin
                            state_reg <= S_OUT;
                        end
                    end
                end
                S_PTR_RD:
                begin
                    state_reg <= S_PTR_USE;
                end
                S_PTR_USE:
                begin
                    if (cmd_reg)
                    begin
                        nonempty_reg[q_reg]  <= (rec_count != CB'(1));
                        ptr_valid_reg[q_reg] <= 1'b1;
                        state_reg            <= S_JOB_RD;
                    end
                    else
                    begin
                        if (is_full)
                        begin
                            dropped_reg <= 1'b1;
                        end
                        else
                        begin
                            nonempty_reg[q_reg]  <= 1'b1;
                            ptr_valid_reg[q_reg] <= 1'b1;
                        end
                        state_reg <= S_OUT;
                    end
                end
                S_JOB_RD:
                begin
                    job_valid_reg <= 1'b1;
                    job_out_reg   <= job_rd16;
                    state_reg     <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Job store for all FIFOs
    wsjd_ram #(
        .WIDTH (JOB_BITS),
        .DEPTH (JDEP)
    ) u_job_ram (
        .clk     (clk),
        .wr_en   (job_wr_en),
        .wr_addr (job_wr_addr),
        .wr_data (job_reg),
        .rd_en   (job_rd_en),
        .rd_addr (job_rd_addr),
        .rd_data (job_rd_data)
    );

    // Head, tail and count of each FIFO
    wsjd_ram #(
        .WIDTH (REC_W),
        .DEPTH (NQ)
    ) u_ptr_ram (
        .clk     (clk),
        .wr_en   (ptr_wr_en),
        .wr_addr (q_reg),
        .wr_data (ptr_wr_data),
        .rd_en   (ptr_rd_en),
        .rd_addr (q_reg),
        .rd_data (ptr_rd_data)
    );

    // Steal scan over the other workers
    wsjd_scan #(
        .NUM_WORKERS (NUM_WORKERS)
    ) u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (scan_start),
        .start_worker (w_reg),
        .nonempty     (nonempty_reg[NUM_WORKERS-1:0]),
        .status       (scan_status),
        .victim       (scan_victim)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign job_valid = job_valid_reg;
    assign job_out   = job_out_reg;
    assign source    = source_reg;
    assign victim    = victim_reg;
    assign dropped   = dropped_reg;

endmodule

### bench/wsjd_checker.sv
package wsjd_tb_pkg;

    // Item commands
    typedef enum logic {
        CMD_ENQUEUE = 1'b0,
        CMD_DEQUEUE = 1'b1
    } wsjd_cmd_e;

endpackage

module wsjd_checker
    import wsjd_pkg::*;
    import wsjd_tb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic                command,
    input  logic                has_context,
    input  logic [WORKER_W-1:0] worker,
    input  logic [JOB_W-1:0]    job,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic                job_valid,
    input  logic [JOB_W-1:0]    job_out,
    input  logic [SOURCE_W-1:0] source,
    input  logic [WORKER_W-1:0] victim,
    input  logic                dropped,
    output int                  fail_count,
    output int                  pending_count,
    output int                  item_count,
    output int                  steal_count,
    output int                  drop_count,
    output int                  empty_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NW       = NUM_WORKERS_DEF;
    localparam int DEPTH    = FIFO_DEPTH_DEF;
    localparam int NQ       = NW + 1;
    localparam int GLOBAL_Q = NW;

    typedef struct packed {
        logic                job_valid;
        logic [JOB_W-1:0]    job_out;
        logic [SOURCE_W-1:0] source;
        logic [WORKER_W-1:0] victim;
        logic                dropped;
    } dispatch_result_t;

    // Shadow copy of the job FIFOs; the last one is the global FIFO
    logic [JOB_W-1:0] job_ram [NQ][DEPTH];
    int unsigned      head_ptr  [NQ];
    int unsigned      tail_ptr  [NQ];
    int unsigned      occupancy [NQ];

    dispatch_result_t expected_results [$];

    // Append a job; report false when the FIFO is full
    function automatic bit fifo_push(int q, logic [JOB_W-1:0] jb);
        if (occupancy[q] >= DEPTH)
            return 1'b0;
        job_ram[q][tail_ptr[q]] = jb;
        tail_ptr[q] = (tail_ptr[q] + 1) % DEPTH;
        occupancy[q]++;
        return 1'b1;
    endfunction

    // Take the head job; report false when the FIFO is empty
    function automatic bit fifo_pop(int q, output logic [JOB_W-1:0] jb);
        jb = '0;
        if (occupancy[q] == 0)
            return 1'b0;
        jb = job_ram[q][head_ptr[q]];
        head_ptr[q] = (head_ptr[q] + 1) % DEPTH;
        occupancy[q]--;
        return 1'b1;
    endfunction

    // Apply one item to the shadow FIFOs and work out its result beat
    function automatic dispatch_result_t dispatch_predict(logic cmd, logic ctx,
                                                          logic [WORKER_W-1:0] wk,
                                                          logic [JOB_W-1:0] jb);
        dispatch_result_t r;
        logic [JOB_W-1:0] got;
        int w;
        int v;
        r = '0;
        w = int'(wk) % NW;
        if (cmd == CMD_ENQUEUE) begin
            r.dropped = !fifo_push(ctx ? w : GLOBAL_Q, jb);
            return r;
        end
        if (fifo_pop(w, got)) begin
            r.job_valid = 1'b1;
            r.job_out   = got;
            r.source    = SRC_OWN;
            return r;
        end
        if (fifo_pop(GLOBAL_Q, got)) begin
            r.job_valid = 1'b1;
            r.job_out   = got;
            r.source    = SRC_GLOBAL;
            return r;
        end
        // Steal: scan upward from the next worker, wrapping around
        for (int k = 1; k < NW; k++) begin
            v = (w + k) % NW;
            if (fifo_pop(v, got)) begin
                r.job_valid = 1'b1;
                r.job_out   = got;
                r.source    = SRC_STOLEN;
                r.victim    = WORKER_W'(v);
                return r;
            end
        end
        return r;
    endfunction

    task automatic check_field(string name, logic [JOB_W-1:0] want, logic [JOB_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    // Check result beats against the oldest prediction, then predict new items
    always @(posedge clk or negedge rst_n)
    begin
        dispatch_result_t want;
        if (!rst_n)
        begin
            for (int q = 0; q < NQ; q++)
            begin
                head_ptr[q]  = 0;
                tail_ptr[q]  = 0;
                occupancy[q] = 0;
            end
            expected_results.delete();
            fail_count    = 0;
            item_count    = 0;
            steal_count   = 0;
            drop_count    = 0;
            empty_count   = 0;
            pending_count <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result beat with no item outstanding");
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("job_valid", JOB_W'(want.job_valid), JOB_W'(job_valid));
                    check_field("job_out", want.job_out, job_out);
                    check_field("source", JOB_W'(want.source), JOB_W'(source));
                    check_field("victim", JOB_W'(want.victim), JOB_W'(victim));
                    check_field("dropped", JOB_W'(want.dropped), JOB_W'(dropped));
                end
            end
            if (in_valid && in_ready)
            begin
                want = dispatch_predict(command, has_context, worker, job);
                expected_results.push_back(want);
                item_count++;
                if (want.dropped)
                    drop_count++;
                if (command == CMD_DEQUEUE && !want.job_valid)
                    empty_count++;
                if (want.job_valid && want.source == SRC_STOLEN)
                    steal_count++;
            end
            pending_count <= expected_results.size();
        end
    end

endmodule

### bench/tb_work_stealing_job_dispatcher.sv
module tb_work_stealing_job_dispatcher import wsjd_pkg::*, wsjd_tb_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 400;

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                in_valid    = 1'b0;
    logic                in_ready;
    logic                command     = CMD_ENQUEUE;
    logic                has_context = 1'b0;
    logic [WORKER_W-1:0] worker      = '0;
    logic [JOB_W-1:0]    job         = '0;
    logic                out_valid;
    logic                out_ready   = 1'b0;
    logic                job_valid;
    logic [JOB_W-1:0]    job_out;
    logic [SOURCE_W-1:0] source;
    logic [WORKER_W-1:0] victim;
    logic                dropped;

    int fail_count;
    int pending_count;
    int item_count;
    int steal_count;
    int drop_count;
    int empty_count;

    int send_idle = 25;
    int recv_idle = 47;
    int hold_req_count = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int cycle_count = 0;

    work_stealing_job_dispatcher dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .has_context (has_context),
        .worker      (worker),
        .job         (job),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .job_valid   (job_valid),
        .job_out     (job_out),
        .source      (source),
        .victim      (victim),
        .dropped     (dropped)
    );

    wsjd_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command       (command),
        .has_context   (has_context),
        .worker        (worker),
        .job           (job),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .job_valid     (job_valid),
        .job_out       (job_out),
        .source        (source),
        .victim        (victim),
        .dropped       (dropped),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .item_count    (item_count),
        .steal_count   (steal_count),
        .drop_count    (drop_count),
        .empty_count   (empty_count)
    );

    always #2 clk = ~clk;

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("** work_stealing_job_dispatcher: FAILED **");
            $finish;
        end
    end

    // Receiver: random back-pressure, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_seen != hold_req_count)
        begin
            hold_seen <= hold_req_count;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    // Job handle with the extremes mixed in
    function automatic logic [JOB_W-1:0] rand_job();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: return JOB_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // Offer one beat after a random gap and hold it until accepted
    task automatic send_item(logic cmd, logic ctx, logic [WORKER_W-1:0] wk,
                             logic [JOB_W-1:0] jb);
        while ($urandom_range(0, 99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        command     <= cmd;
        has_context <= ctx;
        worker      <= wk;
        job         <= jb;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Bursts of enqueues followed by bursts of dequeues from random workers
    task automatic run_mixed(int n);
        int sent;
        int burst;
        sent = 0;
        while (sent < n)
        begin
            burst = $urandom_range(1, 6);
            repeat (burst)
            begin
                send_item(CMD_ENQUEUE, 1'($urandom_range(0, 1)),
                          WORKER_W'($urandom_range(0, 3)), rand_job());
                sent++;
            end
            burst = $urandom_range(1, 8);
            repeat (burst)
            begin
                send_item(CMD_DEQUEUE, 1'($urandom_range(0, 1)),
                          WORKER_W'($urandom_range(0, 3)), rand_job());
                sent++;
            end
        end
    endtask

    // Overfill one FIFO; every sixteenth beat goes to a different FIFO
    task automatic flood_fifo(int n);
        logic                ctx;
        logic [WORKER_W-1:0] tgt;
        ctx = 1'($urandom_range(0, 1));
        tgt = WORKER_W'($urandom_range(0, 3));
        for (int i = 0; i < n; i++)
        begin
            if (i % 16 == 15)
                send_item(CMD_ENQUEUE, !ctx, tgt + 1'b1, rand_job());
            else
                send_item(CMD_ENQUEUE, ctx, tgt, rand_job());
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty dequeues, own, global and steal paths with wrap
        send_item(CMD_DEQUEUE, 1'b0, 2'd0, 16'h0000);
        send_item(CMD_DEQUEUE, 1'b1, 2'd3, 16'hFFFF);
        send_item(CMD_ENQUEUE, 1'b0, 2'd0, 16'h0000);
        send_item(CMD_ENQUEUE, 1'b0, 2'd2, 16'hFFFF);
        send_item(CMD_ENQUEUE, 1'b1, 2'd1, 16'hA5A5);
        send_item(CMD_ENQUEUE, 1'b1, 2'd3, 16'h5A5A);
        send_item(CMD_DEQUEUE, 1'b0, 2'd1, 16'h0000);
        send_item(CMD_DEQUEUE, 1'b0, 2'd1, 16'hFFFF);
        send_item(CMD_DEQUEUE, 1'b1, 2'd0, 16'h0000);
        send_item(CMD_DEQUEUE, 1'b0, 2'd0, 16'h0000);
        send_item(CMD_ENQUEUE, 1'b1, 2'd0, 16'h1234);
        send_item(CMD_DEQUEUE, 1'b0, 2'd3, 16'h0000);
        send_item(CMD_ENQUEUE, 1'b1, 2'd2, 16'h8001);
        send_item(CMD_DEQUEUE, 1'b0, 2'd1, 16'h0000);
        send_item(CMD_ENQUEUE, 1'b1, 2'd1, 16'h7FFE);
        send_item(CMD_ENQUEUE, 1'b1, 2'd2, 16'h0001);
        send_item(CMD_DEQUEUE, 1'b0, 2'd0, 16'h0000);
        send_item(CMD_DEQUEUE, 1'b1, 2'd3, 16'h0000);
        send_item(CMD_ENQUEUE, 1'b0, 2'd3, 16'hFFFF);
        send_item(CMD_DEQUEUE, 1'b0, 2'd2, 16'h0000);
        send_item(CMD_DEQUEUE, 1'b0, 2'd2, 16'h0000);

        // Random rounds, each with its own idling pattern
        for (int r = 0; r < 3; r++)
        begin
            case (r)
                0:
                begin
                    send_idle = 25;
                    recv_idle = 47;
                end
                1:
                begin
                    send_idle = 47;
                    recv_idle = 25;
                end
                default:
                begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            if (r == 2)
                hold_req_count++;
            run_mixed(20);
            if (r == 1)
                flood_fifo(1120);
            run_mixed(10);
        end
        in_valid <= 1'b0;
        @(posedge clk);

        // Drain, then watch for stray beats
        while (pending_count != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        $display("Covered %0d items: %0d steals, %0d drops on a full FIFO, %0d empty dequeues.",
                 item_count, steal_count, drop_count, empty_count);
        if (fail_count == 0)
            $display("** work_stealing_job_dispatcher: PASSED **");
        else
            $display("** work_stealing_job_dispatcher: FAILED **");
        $finish;
    end

endmodule
